[design/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the exponential soft-clip block
// Holds the register map, the per-word sideband type and the fixed curve
// math used to build the exponent tables at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

  // Register map (word index = paddr[3:2])
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_DRIVE   = 2'd0;
  localparam logic [1:0] REG_WET     = 2'd1;
  localparam logic [1:0] REG_DIVISOR = 2'd2;

  // Register reset values and limits
  localparam logic [6:0] DRIVE_RESET   = 7'd0;
  localparam logic [6:0] WET_RESET     = 7'd0;
  localparam logic [7:0] DIVISOR_RESET = 8'd10;
  localparam logic [6:0] PCT_MAX       = 7'd100;

  // Integer part of the exponent: exp(-n) for n below INT_DEPTH, zero from INT_DEPTH up
  localparam int unsigned INT_BITS  = 4;
  localparam int unsigned INT_DEPTH = 1 << INT_BITS;

  // Q2.30 unity
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Output sample limits
  localparam logic [15:0] SAMPLE_MAX     = 16'h7fff;
  localparam logic [15:0] SAMPLE_MIN_MAG = 16'h8000;

  typedef struct packed {
    logic [6:0] drive_level;
    logic [6:0] wet_mix;
    logic [7:0] curve_divisor;
  } cfg_t;

  // Data that rides along with each word through the pipeline
  typedef struct packed {
    logic signed [15:0] sample;
    logic               block_end;
  } side_t;

  typedef logic [INT_DEPTH-1:0][30:0] int_tab_t;

  // Unsigned quotient by shift and subtract, one bit per loop pass.
  // Evaluated at elaboration only.
  function automatic logic [63:0] udiv_u64(input logic [63:0] num,
                                           input logic [63:0] dvs);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-t) in Q2.30 for t in Q30, 0 <= t <= 1.0: truncated series for
  // exp(+t), then rounded reciprocal. Evaluated at elaboration only.
  function automatic logic [30:0] neg_exp_q30(input logic [63:0] t);
    logic [63:0] sum_acc;
    logic [63:0] term;
    sum_acc = 64'(Q30_ONE);
    term    = 64'(Q30_ONE);
    for (int k = 1; k <= 24; k++) begin
      term    = udiv_u64((term * t) >> 30, 64'(k));
      sum_acc = sum_acc + term;
    end
    return 31'(udiv_u64((64'd1 << 60) + (sum_acc >> 1), sum_acc));
  endfunction

  // exp(-n) in Q2.30 by repeated rounded multiply with exp(-1)
  function automatic int_tab_t build_int_tab();
    int_tab_t    tab;
    logic [63:0] e1;
    e1     = 64'(neg_exp_q30(64'(Q30_ONE)));
    tab[0] = 31'(Q30_ONE);
    for (int i = 1; i < INT_DEPTH; i++) begin
      tab[i] = 31'(((64'(tab[i-1]) * e1) + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam int_tab_t INT_TAB = build_int_tab();

endpackage

`default_nettype wire

[design/esc_regs.sv]
// ----------------------------------------------------------------------------
// esc_regs: configuration register file
// APB-style write/read of drive level, wet mix and curve divisor. Writes of
// out-of-range values leave the register unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [esc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      esc_pkg::cfg_t              cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx = paddr[3:2];
  assign wr  = psel & penable & pwrite;

  // Update on the access cycle; drop illegal values
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_level   <= esc_pkg::DRIVE_RESET;
      cfg.wet_mix       <= esc_pkg::WET_RESET;
      cfg.curve_divisor <= esc_pkg::DIVISOR_RESET;
    end else if (wr) begin
      unique case (idx)
        esc_pkg::REG_DRIVE: begin
          if (pwdata[6:0] <= esc_pkg::PCT_MAX) cfg.drive_level <= pwdata[6:0];
        end
        esc_pkg::REG_WET: begin
          if (pwdata[6:0] <= esc_pkg::PCT_MAX) cfg.wet_mix <= pwdata[6:0];
        end
        esc_pkg::REG_DIVISOR: begin
          if (pwdata[7:0] != 8'd0) cfg.curve_divisor <= pwdata[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      esc_pkg::REG_DRIVE:   prdata = 32'(cfg.drive_level);
      esc_pkg::REG_WET:     prdata = 32'(cfg.wet_mix);
      esc_pkg::REG_DIVISOR: prdata = 32'(cfg.curve_divisor);
      default:              prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

[design/esc_div.sv]
// ----------------------------------------------------------------------------
// esc_div: pipelined restoring divider for the exponent
// Computes floor(prod * 2^(QBITS-4) / den) one quotient bit per stage and
// flags quotients of 16.0 or more, where the curve is fully saturated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_div #(
  parameter int QBITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               run,
  input  wire logic               in_vld,
  input  wire esc_pkg::side_t     in_side,
  input  wire logic [22:0]        prod,
  input  wire logic [22:0]        den,
  output      logic               out_vld,
  output      esc_pkg::side_t     out_side,
  output      logic [QBITS-1:0]   out_quot,
  output      logic               out_ovf
);

  logic           vld_s  [QBITS+1];
  esc_pkg::side_t side_s [QBITS+1];
  logic           ovf_s  [QBITS+1];
  logic [22:0]    rem_s  [QBITS];
  logic [3:0]     nib_s  [4];
  logic [QBITS-1:0] quot_s [1:QBITS];

  // Setup: range check and initial partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (run) begin
      vld_s[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      side_s[0] <= in_side;
      ovf_s[0]  <= {4'b0, prod} >= {den, 4'b0};
      rem_s[0]  <= {4'b0, prod[22:4]};
      nib_s[0]  <= prod[3:0];
    end
  end

  // One quotient bit per stage
  for (genvar j = 0; j < QBITS; j++) begin : g_step
    logic             bit_in;
    logic [23:0]      trial;
    logic             ge;
    logic [QBITS-1:0] quot_next;

    if (j < 4) begin : g_nib
      assign bit_in = nib_s[j][3-j];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {rem_s[j], bit_in};
    assign ge    = trial >= {1'b0, den};

    if (j == 0) begin : g_first
      assign quot_next = QBITS'(ge);
    end else begin : g_next
      assign quot_next = {quot_s[j][QBITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[j+1] <= 1'b0;
      end else if (run) begin
        vld_s[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (run) begin
        side_s[j+1] <= side_s[j];
        ovf_s[j+1]  <= ovf_s[j];
        quot_s[j+1] <= quot_next;
      end
    end

    // Subtract when the divisor fits
    if (j < QBITS - 1) begin : g_rem
      logic [23:0] diff;
      assign diff = trial - {1'b0, den};
      always_ff @(posedge clk) begin
        if (run) rem_s[j+1] <= ge ? diff[22:0] : trial[22:0];
      end
    end

    // Carry the low numerator bits while they are still needed
    if (j < 3) begin : g_carry
      always_ff @(posedge clk) begin
        if (run) nib_s[j+1] <= nib_s[j];
      end
    end
  end

  assign out_vld  = vld_s[QBITS];
  assign out_side = side_s[QBITS];
  assign out_quot = quot_s[QBITS];
  assign out_ovf  = ovf_s[QBITS];

endmodule

`default_nettype wire

[design/esc_shape.sv]
// ----------------------------------------------------------------------------
// esc_shape: exponential curve lookup
// Splits the Q(4.TAB_BITS) exponent into integer and fraction, reads
// exp(-n) and exp(-f) from constant tables, multiplies them and forms the
// shaped magnitude 1 - exp(-a) in Q1.15.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_shape #(
  parameter int TAB_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  run,
  input  wire logic                  in_vld,
  input  wire esc_pkg::side_t        in_side,
  input  wire logic [TAB_BITS+3:0]   quot,
  input  wire logic                  ovf,
  output      logic                  out_vld,
  output      esc_pkg::side_t        out_side,
  output      logic [15:0]           mag
);

  localparam int QBITS      = TAB_BITS + 4;
  localparam int FRAC_DEPTH = 1 << TAB_BITS;

  typedef logic [FRAC_DEPTH-1:0][30:0] frac_rom_t;

  // exp(-f / 2^TAB_BITS) in Q2.30 for every fraction code
  function automatic frac_rom_t build_frac_rom();
    frac_rom_t tab;
    for (int i = 0; i < FRAC_DEPTH; i++) begin
      tab[i] = esc_pkg::neg_exp_q30(64'(i) << (30 - TAB_BITS));
    end
    return tab;
  endfunction

  localparam frac_rom_t FRAC_ROM = build_frac_rom();

  logic           vld_s [4];
  esc_pkg::side_t side_s [4];

  logic [30:0] int_q;
  logic [30:0] frac_q;
  logic [61:0] eprod_q;
  logic [30:0] e_q;

  logic [61:0] e_round;
  logic [31:0] e_raw;
  logic [31:0] m_full;

  assign e_round = eprod_q + 62'(32'h2000_0000);
  assign e_raw   = e_round[61:30];
  assign m_full  = esc_pkg::Q30_ONE - 32'(e_q) + 32'h0000_4000;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
      vld_s[1] <= 1'b0;
      vld_s[2] <= 1'b0;
      vld_s[3] <= 1'b0;
    end else if (run) begin
      vld_s[0] <= in_vld;
      vld_s[1] <= vld_s[0];
      vld_s[2] <= vld_s[1];
      vld_s[3] <= vld_s[2];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      side_s[0] <= in_side;
      side_s[1] <= side_s[0];
      side_s[2] <= side_s[1];
      side_s[3] <= side_s[2];
      // Table reads; saturated exponent gives exp(-a) = 0
      int_q   <= ovf ? 31'd0 : esc_pkg::INT_TAB[quot[QBITS-1:TAB_BITS]];
      frac_q  <= FRAC_ROM[quot[TAB_BITS-1:0]];
      // exp(-n) * exp(-f)
      eprod_q <= 62'(int_q) * 62'(frac_q);
      // Round back to Q2.30, clamp at one
      e_q     <= (e_raw > esc_pkg::Q30_ONE) ? esc_pkg::Q30_ONE[30:0] : e_raw[30:0];
      // 1 - e in Q1.15, rounded
      mag     <= m_full[30:15];
    end
  end

  assign out_vld  = vld_s[3];
  assign out_side = side_s[3];

endmodule

`default_nettype wire

[design/esc_mix.sv]
// ----------------------------------------------------------------------------
// esc_mix: dry/wet mixer
// Forms x*(100-wet)*32768 + wet*s*32767, divides by 100*32768 truncating
// toward zero (shift, then reciprocal multiply with one correction) and
// saturates to 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_mix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               run,
  input  wire logic [6:0]         wet_mix,
  input  wire logic               in_vld,
  input  wire esc_pkg::side_t     in_side,
  input  wire logic [15:0]        mag,
  output      logic               out_vld,
  output      logic signed [15:0] out_sample,
  output      logic               out_block_end
);

  // floor(2^29 / 100)
  localparam logic [22:0] RECIP_100 = 23'd5368709;

  logic vld_s [6];
  logic end_s [6];

  // Stage 1: weighted products
  logic        [6:0]  dry_w;
  logic signed [16:0] shaped;
  logic signed [23:0] dry_prod;
  logic signed [23:0] wet_prod;
  logic signed [23:0] dry_q;
  logic signed [23:0] wet_q;

  assign dry_w    = esc_pkg::PCT_MAX - wet_mix;
  assign shaped   = in_side.sample[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign dry_prod = 24'(in_side.sample) * 24'($signed({1'b0, dry_w}));
  assign wet_prod = 24'(shaped) * 24'($signed({1'b0, wet_mix}));

  // Stage 2: numerator
  logic signed [39:0] num_next;
  logic signed [39:0] num_q;

  assign num_next = (40'(dry_q) <<< 15) + (40'(wet_q) <<< 15) - 40'(wet_q);

  // Stage 3: magnitude over 2^15
  logic [39:0] abs_num;
  logic [21:0] a_q;
  logic        neg_q [3:5];

  assign abs_num = num_q[39] ? 40'(-num_q) : 40'(num_q);

  // Stage 4: quotient estimate
  logic [44:0] recip_prod;
  logic [15:0] qe_q;
  logic [21:0] a2_q;

  assign recip_prod = 45'(a_q) * 45'(RECIP_100);

  // Stage 5: one correction step
  logic [21:0] back;
  logic [21:0] rem;
  logic [15:0] q_q;

  assign back = 22'(qe_q) * 22'(esc_pkg::PCT_MAX);
  assign rem  = a2_q - back;

  // Stage 6: sign and saturate
  logic signed [15:0] y_next;

  always_comb begin
    if (neg_q[5]) begin
      y_next = (q_q > esc_pkg::SAMPLE_MIN_MAG) ? $signed(esc_pkg::SAMPLE_MIN_MAG)
                                                : $signed(16'(17'd0 - 17'(q_q)));
    end else begin
      y_next = (q_q > esc_pkg::SAMPLE_MAX) ? $signed(esc_pkg::SAMPLE_MAX) : $signed(q_q);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) vld_s[i] <= 1'b0;
    end else if (run) begin
      vld_s[0] <= in_vld;
      for (int i = 1; i < 6; i++) vld_s[i] <= vld_s[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      end_s[0] <= in_side.block_end;
      for (int i = 1; i < 6; i++) end_s[i] <= end_s[i-1];
      dry_q    <= dry_prod;
      wet_q    <= wet_prod;
      num_q    <= num_next;
      a_q      <= abs_num[36:15];
      neg_q[3] <= num_q[39];
      qe_q     <= recip_prod[44:29];
      a2_q     <= a_q;
      neg_q[4] <= neg_q[3];
      q_q      <= (rem >= 22'(esc_pkg::PCT_MAX)) ? qe_q + 16'd1 : qe_q;
      neg_q[5] <= neg_q[4];
      out_sample <= y_next;
    end
  end

  assign out_vld       = vld_s[5];
  assign out_block_end = end_s[5];

endmodule

`default_nettype wire

[design/exp_soft_clip_distortion_top.sv]
// ----------------------------------------------------------------------------
// exp_soft_clip_distortion_top: exponential soft-clip distortion with mix
// Shapes each audio sample with 1 - exp(-k*|x|) and blends it with the dry
// sample under register control.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries sample_in and block_end_in; a
//   word is taken on a clock edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries sample_out and block_end_out.
//   Registers (drive_level, wet_mix, curve_divisor) sit on the APB port at
//   byte addresses 0, 4 and 8; write them only while no word is in flight.
//   Throughput is one word per clock while in_stall is low. The exponent
//   divider resolves one quotient bit per stage over CURVE_TABLE_BITS + 4
//   stages.
//   The output register is backed by a skid register: while a result waits
//   under out_stall the pipeline keeps accepting and moving words until
//   one more reaches the skid register; then in_stall rises and it holds.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: drive 0, wet 0, divisor 10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module exp_soft_clip_distortion_top #(
  parameter int CURVE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input channel
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [15:0]         sample_in,
  input  wire logic                       block_end_in,
  // Output channel
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic signed [15:0]         sample_out,
  output      logic                       block_end_out,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [esc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);

  localparam int QUOT_BITS = CURVE_TABLE_BITS + 4;

  esc_pkg::cfg_t cfg;

  esc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // Pipeline runs unless the skid register is occupied
  logic skid_vld;
  logic run;

  assign run      = !skid_vld;
  assign in_stall = skid_vld;

  // Front stage: |x| scaled by drive level + 1
  logic [15:0]    mag_in;
  logic [6:0]     drive_p1;
  logic [22:0]    den;
  logic           a_vld;
  esc_pkg::side_t a_side;
  logic [22:0]    a_prod;

  assign mag_in   = sample_in[15] ? 16'(-sample_in) : 16'(sample_in);
  assign drive_p1 = cfg.drive_level + 7'd1;
  assign den      = {cfg.curve_divisor, 15'd0} - 23'(cfg.curve_divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (run) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      a_side.sample    <= sample_in;
      a_side.block_end <= block_end_in;
      a_prod           <= 23'(drive_p1) * 23'(mag_in);
    end
  end

  // Exponent divider
  logic                 d_vld;
  esc_pkg::side_t       d_side;
  logic [QUOT_BITS-1:0] d_quot;
  logic                 d_ovf;

  esc_div #(
    .QBITS (QUOT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_vld   (a_vld),
    .in_side  (a_side),
    .prod     (a_prod),
    .den      (den),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_quot (d_quot),
    .out_ovf  (d_ovf)
  );

  // Curve lookup
  logic           s_vld;
  esc_pkg::side_t s_side;
  logic [15:0]    s_mag;

  esc_shape #(
    .TAB_BITS (CURVE_TABLE_BITS)
  ) u_shape (
    .clk      (clk),
    .rst      (rst),
    .run      (run),
    .in_vld   (d_vld),
    .in_side  (d_side),
    .quot     (d_quot),
    .ovf      (d_ovf),
    .out_vld  (s_vld),
    .out_side (s_side),
    .mag      (s_mag)
  );

  // Dry/wet mix
  logic               m_vld;
  logic signed [15:0] m_sample;
  logic               m_end;

  esc_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .run           (run),
    .wet_mix       (cfg.wet_mix),
    .in_vld        (s_vld),
    .in_side       (s_side),
    .mag           (s_mag),
    .out_vld       (m_vld),
    .out_sample    (m_sample),
    .out_block_end (m_end)
  );

  // Output register with skid
  logic               incoming;
  logic               out_free;
  logic signed [15:0] skid_sample;
  logic               skid_end;

  assign incoming = run & m_vld;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (out_free) begin
      if (skid_vld) begin
        out_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end else begin
        out_valid <= incoming;
      end
    end else if (incoming) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld) begin
        sample_out    <= skid_sample;
        block_end_out <= skid_end;
      end else if (incoming) begin
        sample_out    <= m_sample;
        block_end_out <= m_end;
      end
    end else if (incoming) begin
      skid_sample <= m_sample;
      skid_end    <= m_end;
    end
  end

endmodule

`default_nettype wire

[design/esc_checker.sv]
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the soft-clip block
// Watches the handshake ports for reset behavior, output hold under stall
// and the skid backpressure relation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] sample_out,
  input wire logic               block_end_out
);

  // Reset empties the output side
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output or stall not cleared after reset");

  // A stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(block_end_out))
    else $error("stalled output word changed");

  // Backpressure only follows a stalled output word
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall rose without a stalled output");

  // A full skid register implies a waiting output word
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled while output empty");

  // Input valid is an upstream signal and is only observed here
  logic in_seen;
  assign in_seen = in_valid;

  assert property (@(posedge clk) disable iff (rst)
    in_seen && in_stall && !out_stall |=> !in_stall)
    else $error("stall held after output drained");

endmodule

bind exp_soft_clip_distortion_top esc_checker u_esc_checker (.*);

`default_nettype wire

[tb/exp_soft_clip_distortion_top_tb.sv]
// ----------------------------------------------------------------------------
// exp_soft_clip_distortion_top_tb: self-checking bench for the soft-clip block
// Drives audio words with random gaps and back-pressure, and programs the
// drive, mix and divisor registers between phases. A scoreboard predicts every
// output word in fixed point from its own exp tables and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exp_soft_clip_distortion_top_tb;

  localparam int TABLE_BITS    = 10;
  localparam int FRAC_SIZE     = 1 << TABLE_BITS;
  localparam int WHOLE_SIZE    = 16;
  localparam int LATENCY       = TABLE_BITS + 17;
  localparam int IDLE_PCT      = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 116;
  localparam int QUIET_PHASE   = 2;
  localparam int HOLD_PHASE    = 5;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int MIX_SCALE     = 100 * 32768;
  localparam longint unsigned UNITY_Q30 = 64'd1 << 30;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [1:0] REG_LIST [3] = '{esc_pkg::REG_DRIVE, esc_pkg::REG_WET,
                                          esc_pkg::REG_DIVISOR};

  typedef struct {
    logic signed [15:0] source;
    logic signed [15:0] sample;
    logic               block_end;
  } mix_word_t;

  // Predicts the mixed output of each accepted word and checks results in order
  class distortion_scoreboard;
    bit [6:0]  drive_level;
    bit [6:0]  wet_mix;
    bit [7:0]  curve_divisor;
    bit [31:0] frac_exp [FRAC_SIZE];
    bit [31:0] whole_exp [WHOLE_SIZE];
    mix_word_t pending_mix [$];
    int        failures;

    function new();
      longint unsigned e1;
      drive_level   = esc_pkg::DRIVE_RESET;
      wet_mix       = esc_pkg::WET_RESET;
      curve_divisor = esc_pkg::DIVISOR_RESET;
      failures      = 0;
      for (int i = 0; i < FRAC_SIZE; i++) begin
        frac_exp[i] = recip_exp_q30(longint'(i) << (30 - TABLE_BITS));
      end
      e1 = recip_exp_q30(UNITY_Q30);
      whole_exp[0] = 32'(UNITY_Q30);
      for (int i = 1; i < WHOLE_SIZE; i++) begin
        whole_exp[i] = 32'((64'(whole_exp[i-1]) * e1 + (64'd1 << 29)) >> 30);
      end
    endfunction

    // exp(-t) in Q2.30: truncated series for exp(+t), then rounded reciprocal
    function bit [31:0] recip_exp_q30(longint unsigned t);
      longint unsigned series;
      longint unsigned term;
      series = UNITY_Q30;
      term   = UNITY_Q30;
      for (int k = 1; k <= 24; k++) begin
        term   = ((term * t) >> 30) / longint'(k);
        series = series + term;
      end
      return 32'(((64'd1 << 60) + series / 2) / series);
    endfunction

    function logic signed [15:0] predict_mix(logic signed [15:0] x);
      longint          xs;
      longint unsigned mag, den, aq, whole, frac, e, m;
      longint          s, wet, num, y;
      xs    = x;
      mag   = (xs < 0) ? -xs : xs;
      den   = longint'(curve_divisor) * 32767;
      aq    = (((longint'(drive_level) + 1) * mag) << TABLE_BITS) / den;
      whole = aq >> TABLE_BITS;
      frac  = aq & (FRAC_SIZE - 1);
      if (whole >= WHOLE_SIZE) e = 0;
      else e = (64'(whole_exp[whole]) * 64'(frac_exp[frac]) + (64'd1 << 29)) >> 30;
      if (e > UNITY_Q30) e = UNITY_Q30;
      m   = (UNITY_Q30 - e + (64'd1 << 14)) >> 15;
      s   = (xs < 0) ? -longint'(m) : longint'(m);
      wet = wet_mix;
      num = xs * (100 - wet) * 32768 + wet * s * 32767;
      y   = num / MIX_SCALE;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return 16'(y);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        esc_pkg::REG_DRIVE: begin
          if (value[6:0] <= esc_pkg::PCT_MAX) drive_level = value[6:0];
        end
        esc_pkg::REG_WET: begin
          if (value[6:0] <= esc_pkg::PCT_MAX) wet_mix = value[6:0];
        end
        esc_pkg::REG_DIVISOR: begin
          if (value[7:0] != 8'd0) curve_divisor = value[7:0];
        end
        default: ;
      endcase
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("[%0t] %s", $time, what);
    endfunction

    function void check_reg(logic [1:0] idx, logic [31:0] got);
      logic [31:0] want;
      case (idx)
        esc_pkg::REG_DRIVE:   want = 32'(drive_level);
        esc_pkg::REG_WET:     want = 32'(wet_mix);
        esc_pkg::REG_DIVISOR: want = 32'(curve_divisor);
        default:              want = got;
      endcase
      if (got !== want) flag($sformatf("register %0d read: expected %0d, got %0d", idx, want, got));
    endfunction

    function void note_input(logic signed [15:0] smp, logic be);
      mix_word_t w;
      w.source    = smp;
      w.sample    = predict_mix(smp);
      w.block_end = be;
      pending_mix.push_back(w);
    endfunction

    function void check_result(logic signed [15:0] smp, logic be);
      mix_word_t w;
      if (pending_mix.size() == 0) begin
        flag($sformatf("unexpected word: sample %0d, block_end %b", smp, be));
        return;
      end
      w = pending_mix.pop_front();
      if (smp !== w.sample || be !== w.block_end) begin
        flag($sformatf("input %0d: expected sample %0d block_end %b, got sample %0d block_end %b",
                       w.source, w.sample, w.block_end, smp, be));
      end
    endfunction

    function int pending();
      return pending_mix.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [15:0]          sample_in;
  logic                        block_end_in;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [15:0]          sample_out;
  logic                        block_end_out;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [esc_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  distortion_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  int cycle_count;

  exp_soft_clip_distortion_top #(
    .CURVE_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .block_end_in (block_end_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .block_end_out(block_end_out),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Note accepted words and check delivered words at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(sample_in, block_end_in);
      if (out_valid && !out_stall) sb.check_result(sample_out, block_end_out);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall <= (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("exp_soft_clip_distortion_top_tb failed");
    $finish;
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic signed [15:0] smp, input logic be);
    @(negedge clk);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    sample_in    <= smp;
    block_end_in <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle until pready
  task automatic reg_access(input logic [1:0] idx, input bit is_write,
                            input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (is_write) sb.write_reg(idx, value);
    else sb.check_reg(idx, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] drive, input logic [6:0] wet,
                            input logic [7:0] divisor);
    reg_access(esc_pkg::REG_DRIVE, 1'b1, 32'(drive));
    reg_access(esc_pkg::REG_WET, 1'b1, 32'(wet));
    reg_access(esc_pkg::REG_DIVISOR, 1'b1, 32'(divisor));
  endtask

  task automatic read_all();
    foreach (REG_LIST[i]) reg_access(REG_LIST[i], 1'b0, 32'd0);
  endtask

  // Drop valid, wait for every expected word, then let the pipe go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] legal_value(input logic [1:0] idx);
    int pick;
    pick = $urandom_range(9);
    if (idx == esc_pkg::REG_DIVISOR) begin
      if (pick == 0) return 32'd1;
      if (pick == 1) return 32'd255;
      if (pick < 7) return $urandom_range(16, 1);
      return $urandom_range(255, 1);
    end
    if (pick == 0) return 32'd0;
    if (pick == 1) return 32'(esc_pkg::PCT_MAX);
    return $urandom_range(int'(esc_pkg::PCT_MAX));
  endfunction

  // Mostly full-range words, with small and near-full-scale ones mixed in
  function automatic logic signed [15:0] random_sample();
    int pick;
    pick = $urandom_range(19);
    if (pick < 12) return 16'($urandom());
    if (pick < 15) return 16'(int'($urandom_range(1023)) - 512);
    if (pick < 18) begin
      if (pick[0]) return 16'(32767 - int'($urandom_range(63)));
      return 16'(-32768 + int'($urandom_range(63)));
    end
    return pick[0] ? 16'sh7fff : 16'sh8000;
  endfunction

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    sample_in    = '0;
    block_end_in = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tx_idle_pct  = IDLE_PCT;
    rx_idle_pct  = IDLE_PCT;
    hold_request = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: dry path passes the word through
    read_all();
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh0000, 1'b0);
    send_word(-16'sd1, 1'b0);
    settle();

    // Steepest curve, fully wet
    set_config(esc_pkg::PCT_MAX, esc_pkg::PCT_MAX, 8'd1);
    send_word(16'sh0000, 1'b1);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh5555, 1'b1);
    send_word(16'shaaaa, 1'b0);
    settle();

    // Out-of-range percents, zero divisor and an unused index leave registers alone
    reg_access(esc_pkg::REG_DRIVE, 1'b1, 32'd101);
    reg_access(esc_pkg::REG_WET, 1'b1, 32'd127);
    reg_access(esc_pkg::REG_DIVISOR, 1'b1, 32'd0);
    reg_access(REG_UNUSED, 1'b1, 32'hffff_ffff);
    read_all();
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b1);
    settle();

    // Shallowest curve, fully wet
    set_config(7'd0, esc_pkg::PCT_MAX, 8'd255);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd1, 1'b1);
    send_word(-16'sd1, 1'b0);
    send_word(16'sh0000, 1'b0);
    settle();

    // Partial mix
    set_config(7'd50, 7'd37, 8'd7);
    send_word(16'sd12345, 1'b1);
    send_word(-16'sd12345, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    settle();

    // Random phases, each under a new register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      foreach (REG_LIST[i]) begin
        if ($urandom_range(3) == 0) reg_access(REG_LIST[i], 1'b1, $urandom());
        reg_access(REG_LIST[i], 1'b1, legal_value(REG_LIST[i]));
      end
      read_all();
      tx_idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      rx_idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (ph == HOLD_PHASE && w == PHASE_WORDS / 4) hold_request = 1'b1;
        send_word(random_sample(), $urandom_range(7) == 0);
      end
      settle();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("exp_soft_clip_distortion_top_tb passed");
    end else begin
      $display("exp_soft_clip_distortion_top_tb failed");
    end
    $finish;
  end

endmodule
